// ----- src/gpmd_pkg.sv -----
package gpmd_pkg;

  // Width of the configuration address and data.
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // Product of a 24-bit coefficient and a 9-bit signed coordinate.
  localparam int unsigned PROD_W = 33;
  // Two products and a 32-bit offset.
  localparam int unsigned SUM_W = 35;

  localparam logic CMD_MERGE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Every cell holds this value after the clearing pass.
  localparam logic signed [7:0] RESET_CODE = 8'sd51;

  localparam logic [7:0] COST_UNKNOWN   = 8'd255;
  localparam logic [7:0] COST_LETHAL    = 8'd254;
  localparam logic [7:0] COST_INSCRIBED = 8'd253;
  localparam logic [7:0] COST_FREE      = 8'd0;

  typedef enum logic [2:0] {
    REG_UNKNOWN   = 3'd0,
    REG_INSCRIBED = 3'd1,
    REG_ROT_COS   = 3'd2,
    REG_ROT_SIN   = 3'd3,
    REG_X_OFFSET  = 3'd4,
    REG_Y_OFFSET  = 3'd5,
    REG_LAYER_EN  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [7:0]  unknown_code;
    logic signed [7:0]  inscribed_code;
    logic signed [23:0] rot_cos;
    logic signed [23:0] rot_sin;
    logic signed [31:0] x_offset;
    logic signed [31:0] y_offset;
    logic               layer_enable;
  } cfg_t;

  typedef enum logic [1:0] {
    RES_MERGE = 2'd0,
    RES_OFF   = 2'd1,
    RES_READ  = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic      cap;
    logic      clr_wr;
    logic      tgt_wr;
    logic      tgt_rd;
    logic      cell_from_mem;
    logic      nbr_rd;
    logic [2:0] nbr_idx;
    logic      nbr_chk;
    logic      rd_issue;
    logic      out_ld;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic off_grid;
    logic val_unknown;
    logic cell_obst;
    logic out_busy;
  } dp_sts_t;

endpackage

// ----- src/gpmd_regs.sv -----
module gpmd_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gpmd_pkg::PADDR_W-1:0]     paddr,
  input  logic [gpmd_pkg::PDATA_W-1:0]     pwdata,
  output logic [gpmd_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  output gpmd_pkg::cfg_t                   cfg
);

  gpmd_pkg::cfg_t   cfg_r;
  gpmd_pkg::reg_idx_t idx;
  logic             wr;

  assign idx    = gpmd_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unknown_code   <= 8'sd51;
      cfg_r.inscribed_code <= 8'sd50;
      cfg_r.rot_cos        <= 24'sd65536;
      cfg_r.rot_sin        <= '0;
      cfg_r.x_offset       <= '0;
      cfg_r.y_offset       <= '0;
      cfg_r.layer_enable   <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        gpmd_pkg::REG_UNKNOWN:   cfg_r.unknown_code   <= pwdata[7:0];
        gpmd_pkg::REG_INSCRIBED: cfg_r.inscribed_code <= pwdata[7:0];
        gpmd_pkg::REG_ROT_COS:   cfg_r.rot_cos        <= pwdata[23:0];
        gpmd_pkg::REG_ROT_SIN:   cfg_r.rot_sin        <= pwdata[23:0];
        gpmd_pkg::REG_X_OFFSET:  cfg_r.x_offset       <= pwdata;
        gpmd_pkg::REG_Y_OFFSET:  cfg_r.y_offset       <= pwdata;
        gpmd_pkg::REG_LAYER_EN:  cfg_r.layer_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gpmd_pkg::REG_UNKNOWN:   prdata = {24'd0, cfg_r.unknown_code};
      gpmd_pkg::REG_INSCRIBED: prdata = {24'd0, cfg_r.inscribed_code};
      gpmd_pkg::REG_ROT_COS:   prdata = {8'd0, cfg_r.rot_cos};
      gpmd_pkg::REG_ROT_SIN:   prdata = {8'd0, cfg_r.rot_sin};
      gpmd_pkg::REG_X_OFFSET:  prdata = cfg_r.x_offset;
      gpmd_pkg::REG_Y_OFFSET:  prdata = cfg_r.y_offset;
      gpmd_pkg::REG_LAYER_EN:  prdata = {31'd0, cfg_r.layer_enable};
      default:                 prdata = '0;
    endcase
  end

endmodule

// ----- src/gpmd_ctrl.sv -----
module gpmd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_stall,
  input  gpmd_pkg::dp_sts_t sts,
  output gpmd_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CALC, S_TGT, S_TGT_WAIT, S_CHK, S_NBR, S_RD, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  gpmd_pkg::res_kind_t  kind_r, kind_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    kind_nxt          = kind_r;
    cmd               = '0;
    cmd.res_kind      = kind_r;
    cmd.nbr_idx       = cnt_r[2:0];
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          cnt_nxt = '0;
          state_nxt = (in_cmd == gpmd_pkg::CMD_READ) ? S_RD : S_CALC;
        end
      end
      S_CALC: begin
        // Products, sums, rounding and the linear index are each registered in turn.
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd3) state_nxt = S_TGT;
      end
      S_TGT: begin
        priority if (sts.off_grid) begin
          kind_nxt  = gpmd_pkg::RES_OFF;
          state_nxt = S_DONE;
        end else if (!sts.val_unknown) begin
          cmd.tgt_wr = 1'b1;
          state_nxt  = S_CHK;
        end else begin
          cmd.tgt_rd = 1'b1;
          state_nxt  = S_TGT_WAIT;
        end
      end
      S_TGT_WAIT: begin
        cmd.cell_from_mem = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cnt_nxt  = '0;
        kind_nxt = gpmd_pkg::RES_MERGE;
        state_nxt = sts.cell_obst ? S_NBR : S_DONE;
      end
      S_NBR: begin
        // Each neighbor is read in one state and conditionally written in the next.
        cmd.nbr_rd  = (cnt_r != 4'd8);
        cmd.nbr_chk = (cnt_r != 4'd0);
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd8) state_nxt = S_DONE;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        kind_nxt  = gpmd_pkg::RES_READ;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      kind_r  <= gpmd_pkg::RES_MERGE;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

// ----- src/gpmd_dp.sv -----
module gpmd_dp #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gpmd_pkg::cfg_t        cfg,
  input  gpmd_pkg::dp_cmd_t     cmd,
  output gpmd_pkg::dp_sts_t     sts,
  input  logic [7:0]            in_patch_col,
  input  logic [7:0]            in_patch_row,
  input  logic signed [7:0]     in_cell_value,
  input  logic [7:0]            in_read_col,
  input  logic [7:0]            in_read_row,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_cost,
  output logic                  out_cost_valid,
  output logic                  out_off_grid
);

  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = gpmd_pkg::SUM_W;
  localparam int PW    = gpmd_pkg::PROD_W;
  localparam int CXW   = SW + 1;
  localparam int CBW   = $clog2(GRID_COLS) + 2;
  localparam int IW    = CXW + CBW + 1;
  localparam int NW    = AW + 2;

  localparam logic [SW:0]           HALF    = (SW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [CBW-1:0] COLS_S  = CBW'(GRID_COLS);
  localparam logic signed [IW-1:0]  CELLS_I = IW'(CELLS);
  localparam logic signed [NW-1:0]  CELLS_N = NW'(CELLS);
  localparam logic signed [NW-1:0]  NCOLS   = NW'(GRID_COLS);
  localparam logic signed [NW-1:0]  NONE    = NW'(1);

  // Captured item.
  logic [7:0]        col_r, row_r, rc_r, rr_r;
  logic signed [7:0] val_r;

  // Coordinate pipeline, free running on the captured item.
  logic signed [PW-1:0]  pcc_r, psr_r, psc_r, pcr_r;
  logic signed [SW-1:0]  xf_r, yf_r;
  logic signed [CXW-1:0] cx_r, cy_r;
  logic signed [IW-1:0]  idx_r;

  logic [7:0]        mem [CELLS];
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [7:0]        wdata;
  logic [7:0]        rdata_r;

  logic [AW-1:0]     clr_r;
  logic signed [7:0] cell_r;

  logic signed [NW-1:0] nbr_off, nbr_n;
  logic                 nbr_ok;
  logic [AW-1:0]        nbr_addr_r;
  logic                 nbr_ok_r;

  logic              rd_oob;
  logic [AW-1:0]     rd_addr;

  logic              out_valid_r;
  logic [7:0]        out_cost_r;
  logic              out_cost_valid_r;
  logic              out_off_r;

  function automatic logic signed [CXW-1:0] round_cells(input logic signed [SW-1:0] v);
    logic [SW-1:0] mag;
    logic [SW:0]   sh;
    mag = v[SW-1] ? SW'(-v) : v;
    sh  = ({1'b0, mag} + HALF) >> FRAC_BITS;
    return v[SW-1] ? -$signed(sh) : $signed(sh);
  endfunction

  function automatic logic [7:0] interpret(input logic signed [7:0] c,
                                           input logic signed [7:0] unk,
                                           input logic signed [7:0] ins);
    logic [7:0] r;
    priority if (c == unk) r = gpmd_pkg::COST_UNKNOWN;
    else if (c == ins)     r = gpmd_pkg::COST_INSCRIBED;
    else if (c > unk)      r = gpmd_pkg::COST_LETHAL;
    else                   r = gpmd_pkg::COST_FREE;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      col_r <= in_patch_col;
      row_r <= in_patch_row;
      val_r <= in_cell_value;
      rc_r  <= in_read_col;
      rr_r  <= in_read_row;
    end
    pcc_r <= cfg.rot_cos * $signed({1'b0, col_r});
    psr_r <= cfg.rot_sin * $signed({1'b0, row_r});
    psc_r <= cfg.rot_sin * $signed({1'b0, col_r});
    pcr_r <= cfg.rot_cos * $signed({1'b0, row_r});
    xf_r  <= SW'(pcc_r) - SW'(psr_r) - SW'(cfg.x_offset);
    yf_r  <= SW'(psc_r) + SW'(pcr_r) - SW'(cfg.y_offset);
    cx_r  <= round_cells(xf_r);
    cy_r  <= round_cells(yf_r);
    idx_r <= IW'(cy_r * COLS_S) + IW'(cx_r);
  end

  // Neighbor offsets in the order the grid is swept; columns wrap across rows.
  always_comb begin
    unique case (cmd.nbr_idx)
      3'd0:    nbr_off = NCOLS + NONE;
      3'd1:    nbr_off = NCOLS;
      3'd2:    nbr_off = NCOLS - NONE;
      3'd3:    nbr_off = NONE;
      3'd4:    nbr_off = -NONE;
      3'd5:    nbr_off = -NCOLS + NONE;
      3'd6:    nbr_off = -NCOLS;
      default: nbr_off = -NCOLS - NONE;
    endcase
    nbr_n  = $signed({2'b00, idx_r[AW-1:0]}) + nbr_off;
    nbr_ok = !nbr_n[NW-1] && (nbr_n < CELLS_N);
  end

  assign rd_oob  = (32'(rc_r) >= 32'(GRID_COLS)) || (32'(rr_r) >= 32'(GRID_ROWS));
  assign rd_addr = AW'(32'(rr_r) * 32'(GRID_COLS) + 32'(rc_r));

  always_comb begin
    we    = 1'b0;
    waddr = clr_r;
    wdata = gpmd_pkg::RESET_CODE;
    priority if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.tgt_wr) begin
      we    = 1'b1;
      waddr = idx_r[AW-1:0];
      wdata = val_r;
    end else if (cmd.nbr_chk && nbr_ok_r && rdata_r == 8'd0) begin
      we    = 1'b1;
      waddr = nbr_addr_r;
      wdata = cell_r;
    end else begin
      we = 1'b0;
    end

    re    = 1'b0;
    raddr = idx_r[AW-1:0];
    priority if (cmd.tgt_rd) begin
      re = 1'b1;
    end else if (cmd.nbr_rd) begin
      re    = nbr_ok;
      raddr = nbr_n[AW-1:0];
    end else if (cmd.rd_issue) begin
      re    = !rd_oob;
      raddr = rd_addr;
    end else begin
      re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.tgt_wr) cell_r <= val_r;
    else if (cmd.cell_from_mem) cell_r <= rdata_r;
    if (cmd.nbr_rd) begin
      nbr_addr_r <= nbr_n[AW-1:0];
      nbr_ok_r   <= nbr_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_wr) clr_r <= clr_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      unique case (cmd.res_kind)
        gpmd_pkg::RES_OFF: begin
          out_cost_r       <= gpmd_pkg::COST_FREE;
          out_cost_valid_r <= 1'b0;
          out_off_r        <= 1'b1;
        end
        gpmd_pkg::RES_READ: begin
          out_off_r <= 1'b0;
          if (rd_oob) begin
            out_cost_r       <= gpmd_pkg::COST_UNKNOWN;
            out_cost_valid_r <= 1'b0;
          end else begin
            out_cost_r <= interpret(rdata_r, cfg.unknown_code, cfg.inscribed_code);
            out_cost_valid_r <= cfg.layer_enable &&
                                ($signed(rdata_r) != cfg.unknown_code);
          end
        end
        default: begin
          out_cost_r       <= gpmd_pkg::COST_FREE;
          out_cost_valid_r <= 1'b0;
          out_off_r        <= 1'b0;
        end
      endcase
    end
  end

  assign sts.clr_last    = (clr_r == AW'(CELLS - 1));
  assign sts.off_grid    = idx_r[IW-1] || (idx_r >= CELLS_I);
  assign sts.val_unknown = (val_r == cfg.unknown_code);
  assign sts.cell_obst   = (cell_r > cfg.unknown_code);
  assign sts.out_busy    = out_valid_r && out_stall;

  assign out_valid      = out_valid_r;
  assign out_cost       = out_cost_r;
  assign out_cost_valid = out_cost_valid_r;
  assign out_off_grid   = out_off_r;

endmodule

// ----- src/grid_patch_merge_dilate.sv -----
// Occupancy grid with patch merge and one-step dilation. One word is worked
// on at a time. After reset the block sweeps the whole grid memory, one cell
// a cycle, writing the unknown value 51, and holds in_stall high meanwhile;
// register writes are taken throughout. A read word reads the grid memory
// once and then loads its result. A merge word runs the coordinate
// arithmetic (products, sums, rounding, linear index); when its target is off
// the grid it ends there, else a target access follows and, when the target
// cell holds an obstacle, a sweep over the eight neighbors through the grid
// memory's single read and single write port. A finished result waits in the
// output register, and the next word is accepted while it waits.
module grid_patch_merge_dilate #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [7:0]                    in_patch_col,
  input  logic [7:0]                    in_patch_row,
  input  logic signed [7:0]             in_cell_value,
  input  logic [7:0]                    in_read_col,
  input  logic [7:0]                    in_read_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_cost,
  output logic                          out_cost_valid,
  output logic                          out_off_grid,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gpmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [gpmd_pkg::PDATA_W-1:0]  pwdata,
  output logic [gpmd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  gpmd_pkg::cfg_t    cfg;
  gpmd_pkg::dp_cmd_t cmd;
  gpmd_pkg::dp_sts_t sts;

  gpmd_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg (cfg)
  );

  gpmd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_cmd, .in_stall,
    .sts (sts),
    .cmd (cmd)
  );

  gpmd_dp #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk, .rst_n,
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts),
    .in_patch_col, .in_patch_row, .in_cell_value, .in_read_col, .in_read_row,
    .out_valid, .out_stall, .out_cost, .out_cost_valid, .out_off_grid
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in flight");

  a_off_grid_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_off_grid |-> out_cost == gpmd_pkg::COST_FREE && !out_cost_valid)
    else $error("off-grid merge result carries a cost");

  a_valid_cost_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cost_valid |-> out_cost != gpmd_pkg::COST_UNKNOWN && !out_off_grid)
    else $error("valid cost reported for an unknown cell");

endmodule

// ----- tb/sv/grid_patch_merge_dilate_test.sv -----
module grid_patch_merge_dilate_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 256;
  localparam int ROWS = 256;
  localparam int FRAC = 16;
  localparam int CELLS = COLS * ROWS;
  localparam int IDLE_LIMIT = 400000;

  typedef struct {
    logic              cmd;
    logic [7:0]        pcol;
    logic [7:0]        prow;
    logic signed [7:0] val;
    logic [7:0]        rcol;
    logic [7:0]        rrow;
    bit                typed;
    logic [7:0]        cost;
    logic              cvalid;
    logic              offg;
  } word_t;

  typedef struct {
    logic [7:0] cost;
    logic       cvalid;
    logic       offg;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = 1'b0;
  logic [7:0] in_patch_col = '0;
  logic [7:0] in_patch_row = '0;
  logic signed [7:0] in_cell_value = '0;
  logic [7:0] in_read_col = '0;
  logic [7:0] in_read_row = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [7:0] out_cost;
  logic out_cost_valid;
  logic out_off_grid;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [gpmd_pkg::PADDR_W-1:0] paddr = '0;
  logic [gpmd_pkg::PDATA_W-1:0] pwdata = '0;
  logic [gpmd_pkg::PDATA_W-1:0] prdata;
  logic pready;

  always #5 clk = ~clk;

  grid_patch_merge_dilate dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_patch_col(in_patch_col), .in_patch_row(in_patch_row),
    .in_cell_value(in_cell_value), .in_read_col(in_read_col),
    .in_read_row(in_read_row),
    .out_valid(out_valid), .out_stall(out_stall), .out_cost(out_cost),
    .out_cost_valid(out_cost_valid), .out_off_grid(out_off_grid),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the grid and the registers.
  logic signed [7:0] grid_shadow [CELLS];
  gpmd_pkg::cfg_t cfg_shadow;
  result_t expected_q[$];
  int errors = 0;
  int merges = 0;
  int reads = 0;
  int offgrid_seen = 0;
  int idle_cycles = 0;
  bit hold_long = 1'b0;

  int nbr_offsets[8] = '{COLS + 1, COLS, COLS - 1, 1, -1, -COLS + 1, -COLS, -COLS - 1};

  function automatic longint round_half_away(longint v);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r = (mag + (longint'(1) << (FRAC - 1))) >>> FRAC;
    return (v < 0) ? -r : r;
  endfunction

  function automatic logic [7:0] cost_of(logic signed [7:0] c);
    if (c == cfg_shadow.unknown_code) return gpmd_pkg::COST_UNKNOWN;
    if (c == cfg_shadow.inscribed_code) return gpmd_pkg::COST_INSCRIBED;
    if (c > cfg_shadow.unknown_code) return gpmd_pkg::COST_LETHAL;
    return gpmd_pkg::COST_FREE;
  endfunction

  function automatic result_t grid_update(word_t w);
    result_t r;
    longint xf;
    longint yf;
    longint idx;
    longint n;
    logic signed [7:0] c;
    r = '{cost: 8'd0, cvalid: 1'b0, offg: 1'b0};
    if (w.cmd == gpmd_pkg::CMD_MERGE) begin
      xf = longint'(cfg_shadow.rot_cos) * longint'(w.pcol)
         - longint'(cfg_shadow.rot_sin) * longint'(w.prow)
         - longint'(cfg_shadow.x_offset);
      yf = longint'(cfg_shadow.rot_sin) * longint'(w.pcol)
         + longint'(cfg_shadow.rot_cos) * longint'(w.prow)
         - longint'(cfg_shadow.y_offset);
      idx = round_half_away(xf) + round_half_away(yf) * COLS;
      if (idx < 0 || idx >= CELLS) begin
        r.offg = 1'b1;
        return r;
      end
      if (w.val != cfg_shadow.unknown_code) grid_shadow[idx] = w.val;
      c = grid_shadow[idx];
      if (c > cfg_shadow.unknown_code) begin
        foreach (nbr_offsets[k]) begin
          n = idx + nbr_offsets[k];
          if (n >= 0 && n < CELLS && grid_shadow[n] == 0) grid_shadow[n] = c;
        end
      end
    end else begin
      c = grid_shadow[int'(w.rrow) * COLS + int'(w.rcol)];
      r.cost = cost_of(c);
      r.cvalid = cfg_shadow.layer_enable && (c != cfg_shadow.unknown_code);
    end
    return r;
  endfunction

  task automatic cfg_write(gpmd_pkg::reg_idx_t idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      gpmd_pkg::REG_UNKNOWN: cfg_shadow.unknown_code = data[7:0];
      gpmd_pkg::REG_INSCRIBED: cfg_shadow.inscribed_code = data[7:0];
      gpmd_pkg::REG_ROT_COS: cfg_shadow.rot_cos = data[23:0];
      gpmd_pkg::REG_ROT_SIN: cfg_shadow.rot_sin = data[23:0];
      gpmd_pkg::REG_X_OFFSET: cfg_shadow.x_offset = data;
      gpmd_pkg::REG_Y_OFFSET: cfg_shadow.y_offset = data;
      default: cfg_shadow.layer_enable = data[0];
    endcase
  endtask

  task automatic send_word(word_t w, bit no_gap);
    result_t r;
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= w.cmd;
    in_patch_col <= w.pcol;
    in_patch_row <= w.prow;
    in_cell_value <= w.val;
    in_read_col <= w.rcol;
    in_read_row <= w.rrow;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = grid_update(w);
    if (w.typed) r = '{cost: w.cost, cvalid: w.cvalid, offg: w.offg};
    expected_q.push_back(r);
    if (w.cmd == gpmd_pkg::CMD_MERGE) merges++;
    else reads++;
    if (r.offg) offgrid_seen++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic word_t mk(logic cmd, int pc, int pr, int v, int rc, int rr);
    word_t w;
    w = '{cmd: cmd, pcol: pc[7:0], prow: pr[7:0], val: v[7:0], rcol: rc[7:0],
          rrow: rr[7:0], typed: 1'b0, cost: 8'd0, cvalid: 1'b0, offg: 1'b0};
    return w;
  endfunction

  function automatic word_t mkt(word_t w, int cost, int cv, int og);
    w.typed = 1'b1;
    w.cost = cost[7:0];
    w.cvalid = cv[0];
    w.offg = og[0];
    return w;
  endfunction

  function automatic word_t rand_word(bit local_area);
    word_t w;
    int v;
    case ($urandom_range(0, 5))
      0: v = cfg_shadow.unknown_code;
      1: v = cfg_shadow.inscribed_code;
      2: v = 0;
      3: v = 100;
      default: v = $urandom_range(0, 255);
    endcase
    w = mk(1'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom_range(0, 255), v,
           $urandom_range(0, 255), $urandom_range(0, 255));
    // Keep most words in a small window so merges, dilation and reads meet.
    if (local_area) begin
      w.pcol = 8'($urandom_range(0, 7));
      w.prow = 8'($urandom_range(0, 7));
      w.rcol = 8'($urandom_range(0, 9) + ($urandom_range(0, 1) ? 0 : 246));
      w.rrow = 8'($urandom_range(0, 9) + ($urandom_range(0, 3) ? 0 : 246));
    end
    return w;
  endfunction

  // Result checker and receiver side.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: cost %0d valid %0b off %0b",
                 $time, out_cost, out_cost_valid, out_off_grid);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_cost !== e.cost) begin
          $display("%0t: cost expected %0d actual %0d", $time, e.cost, out_cost);
          errors++;
        end
        if (out_cost_valid !== e.cvalid) begin
          $display("%0t: cost_valid expected %0b actual %0b", $time, e.cvalid,
                   out_cost_valid);
          errors++;
        end
        if (out_off_grid !== e.offg) begin
          $display("%0t: off_grid expected %0b actual %0b", $time, e.offg, out_off_grid);
          errors++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else if (hold_long) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_long)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("grid_patch_merge_dilate: mismatch");
        $finish;
      end
    end
  end

  word_t directed[] = '{
    mkt(mk(gpmd_pkg::CMD_READ, 0, 0, 0, 0, 0), 255, 0, 0),
    mkt(mk(gpmd_pkg::CMD_READ, 0, 0, 0, 255, 255), 255, 0, 0),
    mk(gpmd_pkg::CMD_MERGE, 10, 10, 0, 0, 0),
    mk(gpmd_pkg::CMD_MERGE, 11, 10, 0, 0, 0),
    mk(gpmd_pkg::CMD_MERGE, 10, 11, 50, 0, 0),
    mk(gpmd_pkg::CMD_MERGE, 10, 10, 127, 0, 0),
    mkt(mk(gpmd_pkg::CMD_READ, 0, 0, 0, 10, 10), 254, 1, 0),
    mkt(mk(gpmd_pkg::CMD_READ, 0, 0, 0, 11, 10), 254, 1, 0),
    mkt(mk(gpmd_pkg::CMD_READ, 0, 0, 0, 10, 11), 253, 1, 0),
    mkt(mk(gpmd_pkg::CMD_READ, 0, 0, 0, 12, 12), 255, 0, 0),
    mk(gpmd_pkg::CMD_MERGE, 20, 20, 51, 0, 0),
    mk(gpmd_pkg::CMD_MERGE, 255, 255, -128, 0, 0),
    mk(gpmd_pkg::CMD_MERGE, 0, 0, 0, 0, 0),
    mk(gpmd_pkg::CMD_MERGE, 1, 0, 0, 0, 0),
    mk(gpmd_pkg::CMD_MERGE, 0, 1, 0, 0, 0),
    mk(gpmd_pkg::CMD_MERGE, 0, 0, 127, 0, 0),
    mk(gpmd_pkg::CMD_READ, 0, 0, 0, 1, 1),
    mk(gpmd_pkg::CMD_MERGE, 255, 0, 0, 0, 0),
    mk(gpmd_pkg::CMD_MERGE, 255, 0, 100, 0, 0),
    mk(gpmd_pkg::CMD_READ, 0, 0, 0, 0, 1),
    mk(gpmd_pkg::CMD_READ, 0, 0, 0, 255, 0),
    mk(gpmd_pkg::CMD_READ, 0, 0, 0, 20, 20)
  };

  initial begin
    int count;
    cfg_shadow = '{unknown_code: 8'sd51, inscribed_code: 8'sd50, rot_cos: 24'sd65536,
                   rot_sin: 24'sd0, x_offset: 32'sd0, y_offset: 32'sd0, layer_enable: 1'b1};
    foreach (grid_shadow[i]) grid_shadow[i] = gpmd_pkg::RESET_CODE;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i], 1'b0);
    drain();

    // Column wrap and off-grid targets through the offsets.
    cfg_write(gpmd_pkg::REG_X_OFFSET, 32'(-(2 <<< FRAC)));
    cfg_write(gpmd_pkg::REG_Y_OFFSET, 32'(5 <<< FRAC));
    send_word(mkt(mk(gpmd_pkg::CMD_MERGE, 0, 0, 90, 0, 0), 0, 0, 1), 1'b0);
    send_word(mk(gpmd_pkg::CMD_MERGE, 255, 6, 90, 0, 0), 1'b0);
    send_word(mk(gpmd_pkg::CMD_MERGE, 255, 255, 90, 0, 0), 1'b0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          cfg_write(gpmd_pkg::REG_ROT_COS, 32'(65536));
          cfg_write(gpmd_pkg::REG_ROT_SIN, 32'd0);
          cfg_write(gpmd_pkg::REG_X_OFFSET, 32'd0);
          cfg_write(gpmd_pkg::REG_Y_OFFSET, 32'd0);
          cfg_write(gpmd_pkg::REG_UNKNOWN, 32'd51);
          cfg_write(gpmd_pkg::REG_INSCRIBED, 32'd50);
        end
        1: cfg_write(gpmd_pkg::REG_LAYER_EN, 32'd0);
        2: begin
          cfg_write(gpmd_pkg::REG_LAYER_EN, 32'd1);
          cfg_write(gpmd_pkg::REG_UNKNOWN, 32'h80);
          cfg_write(gpmd_pkg::REG_INSCRIBED, 32'h7f);
        end
        3: begin
          cfg_write(gpmd_pkg::REG_UNKNOWN, 32'h7f);
          cfg_write(gpmd_pkg::REG_INSCRIBED, 32'h80);
          cfg_write(gpmd_pkg::REG_ROT_COS, 32'h7fffff);
          cfg_write(gpmd_pkg::REG_ROT_SIN, 32'h800000);
        end
        4: begin
          cfg_write(gpmd_pkg::REG_UNKNOWN, 32'd20);
          cfg_write(gpmd_pkg::REG_INSCRIBED, 32'd30);
          cfg_write(gpmd_pkg::REG_ROT_COS, 32'd46341);
          cfg_write(gpmd_pkg::REG_ROT_SIN, 32'd46341);
          cfg_write(gpmd_pkg::REG_X_OFFSET, 32'h8000_0000);
          cfg_write(gpmd_pkg::REG_Y_OFFSET, 32'h7fff_ffff);
        end
        5: begin
          cfg_write(gpmd_pkg::REG_ROT_COS, 32'd32768);
          cfg_write(gpmd_pkg::REG_ROT_SIN, 32'(-32768));
          cfg_write(gpmd_pkg::REG_X_OFFSET, 32'(-(3 <<< FRAC) - 32768));
          cfg_write(gpmd_pkg::REG_Y_OFFSET, 32'(-(2 <<< FRAC)));
        end
        6: begin
          cfg_write(gpmd_pkg::REG_ROT_COS, 32'(65536));
          cfg_write(gpmd_pkg::REG_ROT_SIN, 32'd0);
          cfg_write(gpmd_pkg::REG_X_OFFSET, 32'h0000_8000);
          cfg_write(gpmd_pkg::REG_Y_OFFSET, 32'hffff_8000);
          cfg_write(gpmd_pkg::REG_UNKNOWN, 32'd51);
          cfg_write(gpmd_pkg::REG_INSCRIBED, 32'd50);
        end
        default: begin
          cfg_write(gpmd_pkg::REG_ROT_COS, 32'(65536 * 3));
          cfg_write(gpmd_pkg::REG_X_OFFSET, 32'd0);
          cfg_write(gpmd_pkg::REG_Y_OFFSET, 32'd0);
        end
      endcase
      count = (phase == 3 || phase == 4) ? 100 : 240;
      for (int n = 0; n < count; n++) begin
        // The receiver holds off while the sender keeps offering words.
        if (phase == 6 && n == 20) begin
          hold_long = 1'b1;
          fork
            begin
              repeat (300) @(posedge clk);
              hold_long = 1'b0;
            end
          join_none
        end
        send_word(rand_word($urandom_range(0, 9) != 0), n % 50 < 10);
      end
      drain();
    end

    $display("Covered %0d merges (%0d off grid) and %0d reads over 8 register settings.",
             merges, offgrid_seen, reads);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("grid_patch_merge_dilate: match");
    end else begin
      $display("grid_patch_merge_dilate: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/gpmd_pkg.sv
src/gpmd_regs.sv
src/gpmd_ctrl.sv
src/gpmd_dp.sv
src/grid_patch_merge_dilate.sv
tb/sv/grid_patch_merge_dilate_test.sv
